FILE: design/nwld_pkg.sv
// Package for the nearest wall line distance block: word types, op codes, states.
`timescale 1ns / 1ps
`default_nettype none
package nwld_pkg;

  localparam int DistW = 17;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] wall_ax;
    logic signed [15:0] wall_ay;
    logic signed [15:0] wall_bx;
    logic signed [15:0] wall_by;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             no_walls;
    logic             table_full;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIFF,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ABS,
    ST_SQR,
    ST_DIV,
    ST_CMP,
    ST_NEXT,
    ST_SQRT,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: design/nwld_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nwld_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/nearest_wall_line_distance.sv
// Nearest wall line distance: wall table, sequencer, shared multiplier, divider, sqrt.
// Clear and append: the result word is registered and valid in the cycle after the input word is taken.
// Query: per wall a read, differences and four multiplies; zero-length walls are skipped, other
// walls take a serial square and a restoring divide (these dominate), and a serial root ends it.
// One word at a time; input stalls while a query runs or a result waits.
// Reset empties the table (count to zero); table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module nearest_wall_line_distance
  import nwld_pkg::*;
#(
  parameter int MAX_WALLS   = 64,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int LW   = 2 * CW + 2;
  localparam int CRW  = 2 * CW + 2;
  localparam int CRSW = 2 * CW + 3;
  localparam int NW   = 4 * CW + 4;
  localparam int SQW  = 2 * CW + 2;
  localparam int RW   = CW + 1;
  localparam int STW  = $clog2(NW + 1);
  localparam int CNTW = $clog2(MAX_WALLS + 1);
  localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  state_e                  state_q, state_d;
  logic [CNTW-1:0]         count_q, count_d;
  logic [CNTW-1:0]         idx_q, idx_d;
  logic signed [CW-1:0]    px_q, px_d, py_q, py_d;
  logic signed [DW-1:0]    ex_q, ex_d, ey_q, ey_d, dx_q, dx_d, dy_q, dy_d;
  logic [LW-1:0]           lsq_q, lsq_d;
  logic signed [CRSW-1:0]  cr_q, cr_d;
  logic [CRW-1:0]          mag_q, mag_d, sh_q, sh_d;
  logic [NW-1:0]           acc_q, acc_d, best_q, best_d;
  logic [LW-1:0]           rem_q, rem_d;
  logic [STW-1:0]          step_q, step_d;
  logic                    found_q, found_d;
  logic [RW-1:0]           root_q, root_d;
  logic [RW:0]             srem_q, srem_d;
  out_word_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    we;
  logic [4*CW-1:0]         wdata;
  logic [4*CW-1:0]         rdata;
  logic signed [DW-1:0]    mul_a, mul_b;
  logic signed [2*DW-1:0]  prod;
  logic                    acc_in;
  logic                    out_free;
  logic [LW:0]             rem_sh;
  logic [RW+2:0]           srem_sh;
  logic [RW+2:0]           trial;
  logic [RW+DistW-1:0]     root_ext;
  logic signed [CW-1:0]    wax, way, wbx, wby;
  logic signed [CW-1:0]    rax, ray, rbx, rby;

  nwld_ram #(
    .Width(4 * CW),
    .Depth(MAX_WALLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // low COORD_WIDTH bits of the raw field, sign taken from bit COORD_WIDTH-1
  assign wax   = CW'($unsigned(in_word_i.wall_ax));
  assign way   = CW'($unsigned(in_word_i.wall_ay));
  assign wbx   = CW'($unsigned(in_word_i.wall_bx));
  assign wby   = CW'($unsigned(in_word_i.wall_by));
  assign wdata = {wax, way, wbx, wby};
  assign rax   = $signed(rdata[4*CW-1:3*CW]);
  assign ray   = $signed(rdata[3*CW-1:2*CW]);
  assign rbx   = $signed(rdata[2*CW-1:CW]);
  assign rby   = $signed(rdata[CW-1:0]);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign acc_in      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign prod     = mul_a * mul_b;
  assign rem_sh   = {rem_q, acc_q[NW-1]};
  assign srem_sh  = {srem_q, acc_q[SQW-1:SQW-2]};
  assign trial    = (RW+3)'({root_q, 2'b01});
  assign root_ext = (RW+DistW)'(root_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    px_d        = px_q;
    py_d        = py_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    lsq_d       = lsq_q;
    cr_d        = cr_q;
    mag_d       = mag_q;
    sh_d        = sh_q;
    acc_d       = acc_q;
    best_d      = best_q;
    rem_d       = rem_q;
    step_d      = step_q;
    found_d     = found_q;
    root_d      = root_q;
    srem_d      = srem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    mul_a       = ex_q;
    mul_b       = ex_q;

    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          case (in_word_i.op)
            OpClear: count_d = '0;
            OpAppend: begin
              if (count_q >= CNTW'(MAX_WALLS)) begin
                out_d.table_full = 1'b1;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OpQuery: begin
              out_valid_d = 1'b0;
              px_d        = CW'($unsigned(in_word_i.point_x));
              py_d        = CW'($unsigned(in_word_i.point_y));
              idx_d       = '0;
              found_d     = 1'b0;
              state_d     = (count_q == '0) ? ST_OUT : ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_d = ST_DIFF;
      ST_DIFF: begin
        ex_d    = DW'(rbx) - DW'(rax);
        ey_d    = DW'(rby) - DW'(ray);
        dx_d    = DW'(px_q) - DW'(rax);
        dy_d    = DW'(py_q) - DW'(ray);
        state_d = ST_MUL0;
      end
      ST_MUL0: begin
        lsq_d   = LW'(prod);
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        mul_a   = ey_q;
        mul_b   = ey_q;
        lsq_d   = lsq_q + LW'(prod);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_b   = dy_q;
        cr_d    = CRSW'(prod);
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a   = ey_q;
        mul_b   = dx_q;
        cr_d    = cr_q - CRSW'(prod);
        state_d = (lsq_q == '0) ? ST_NEXT : ST_ABS;
      end
      ST_ABS: begin
        mag_d   = cr_q[CRSW-1] ? CRW'(-cr_q) : CRW'(cr_q);
        sh_d    = cr_q[CRSW-1] ? CRW'(-cr_q) : CRW'(cr_q);
        acc_d   = '0;
        step_d  = '0;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        acc_d  = (acc_q << 1) + (sh_q[CRW-1] ? NW'(mag_q) : '0);
        sh_d   = sh_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == STW'(CRW - 1)) begin
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sh >= (LW+1)'(lsq_q)) begin
          rem_d = LW'(rem_sh - (LW+1)'(lsq_q));
          acc_d = {acc_q[NW-2:0], 1'b1};
        end else begin
          rem_d = LW'(rem_sh);
          acc_d = {acc_q[NW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STW'(NW - 1)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!found_q || acc_q < best_q) begin
          best_d  = acc_q;
          found_d = 1'b1;
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == count_q) begin
          acc_d   = best_q;
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = found_q ? ST_SQRT : ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_SQRT: begin
        if (srem_sh >= trial) begin
          srem_d = (RW+1)'(srem_sh - trial);
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          srem_d = (RW+1)'(srem_sh);
          root_d = {root_q[RW-2:0], 1'b0};
        end
        acc_d  = acc_q << 2;
        step_d = step_q + 1'b1;
        if (step_q == STW'(RW - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.table_full = 1'b0;
          out_d.no_walls   = !found_q;
          if (!found_q || root_ext > (RW+DistW)'(DistMax)) begin
            out_d.distance = DistMax;
          end else begin
            out_d.distance = DistW'(root_ext);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    lsq_q  <= lsq_d;
    cr_q   <= cr_d;
    mag_q  <= mag_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    best_q <= best_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    srem_q <= srem_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

FILE: dv/nwld_checker.sv
// Checker for the nearest wall line distance block: watches both channels, predicts, compares.
`timescale 1ns / 1ps
module nwld_checker
  import nwld_pkg::*;
#(
  parameter int MAX_WALLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  longint    wall_tab[MAX_WALLS][4];
  int        wall_cnt;
  out_word_t expected_q[$];

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_word_t predict_distance(in_word_t w);
    out_word_t   r;
    longint      ax, ay, ex, ey, lsq, cr, px, py;
    logic [127:0] c2, q;
    logic [63:0] best, d;
    bit          found;
    r = '0;
    case (w.op)
      OpClear: wall_cnt = 0;
      OpAppend: begin
        if (wall_cnt >= MAX_WALLS) begin
          r.table_full = 1'b1;
        end else begin
          wall_tab[wall_cnt][0] = longint'(w.wall_ax);
          wall_tab[wall_cnt][1] = longint'(w.wall_ay);
          wall_tab[wall_cnt][2] = longint'(w.wall_bx);
          wall_tab[wall_cnt][3] = longint'(w.wall_by);
          wall_cnt++;
        end
      end
      OpQuery: begin
        px = longint'(w.point_x);
        py = longint'(w.point_y);
        found = 0;
        best = '0;
        for (int i = 0; i < wall_cnt; i++) begin
          ax = wall_tab[i][0];
          ay = wall_tab[i][1];
          ex = wall_tab[i][2] - ax;
          ey = wall_tab[i][3] - ay;
          lsq = ex * ex + ey * ey;
          if (lsq != 0) begin
            cr = ex * (py - ay) - ey * (px - ax);
            if (cr < 0) cr = -cr;
            c2 = 128'(cr) * 128'(cr);
            q = c2 / 128'(lsq);
            if (!found || q[63:0] < best) begin
              best = q[63:0];
              found = 1;
            end
          end
        end
        if (!found) begin
          r.distance = DistMax;
          r.no_walls = 1'b1;
        end else begin
          d = isqrt(best);
          r.distance = (d > 64'(DistMax)) ? DistMax : d[DistW-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      wall_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        e = predict_distance(in_word_i);
        expected_q = {expected_q, e};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.distance !== out_word_i.distance || e.no_walls !== out_word_i.no_walls ||
              e.table_full !== out_word_i.table_full) begin
            $display("%0t: mismatch exp dist %0d nw %b tf %b act dist %0d nw %b tf %b",
                     $time, e.distance, e.no_walls, e.table_full,
                     out_word_i.distance, out_word_i.no_walls, out_word_i.table_full);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: dv/nearest_wall_line_distance_tb.sv
// Testbench top for the nearest wall line distance block: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module nearest_wall_line_distance_tb;
  import nwld_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_word_t out_word;
  int        fail_count, pending;
  int        cycles = 0;
  int        stall_left = 0;
  bit        calm = 0;

  nearest_wall_line_distance u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_word_i(in_word), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_word_o(out_word)
  );

  nwld_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_word_i(in_word), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_word_i(out_word), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("FAIL nearest_wall_line_distance");
      $finish;
    end
  end

  // result side: random stall per word, with calm stretches
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      stall_left = calm ? 0 : $urandom_range(0, 17);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, logic [15:0] ax, logic [15:0] ay,
                           logic [15:0] bx, logic [15:0] by,
                           logic [15:0] px, logic [15:0] py);
    int gap;
    in_word_t w;
    gap = calm ? 0 : $urandom_range(0, 17);
    w.op = op;
    w.wall_ax = ax; w.wall_ay = ay; w.wall_bx = bx; w.wall_by = by;
    w.point_x = px; w.point_y = py;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rand_word(logic [1:0] op);
    send_word(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord());
  endtask

  task automatic wall(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx, logic [15:0] by);
    send_word(OpAppend, ax, ay, bx, by, 16'($urandom), 16'($urandom));
  endtask

  task automatic query(logic [15:0] px, logic [15:0] py);
    send_word(OpQuery, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), px, py);
  endtask

  initial begin
    logic [15:0] c;
    int nw, nq;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    query(16'h0000, 16'h0000);
    rand_word(2'd3);
    wall(16'h0100, 16'h0100, 16'h0100, 16'h0100);
    query(16'h7fff, 16'h8000);
    wall(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    query(16'h8000, 16'h7fff);
    query(16'h7fff, 16'h8000);
    query(16'h0000, 16'h0000);
    wall(16'h0000, 16'h8000, 16'h0000, 16'h7fff);
    wall(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    query(16'h7fff, 16'h7fff);
    query(16'h8000, 16'h8000);
    query(16'hffff, 16'h0001);
    wall(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    query(16'h7fff, 16'h7fff);
    send_word(OpClear, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    query(16'h1234, 16'h8765);
    // random sequences
    for (int s = 0; s < 24; s++) begin
      if (s == 20) begin
        // hold off until drained, then fill the table past its end
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
        rand_word(OpClear);
        for (int k = 0; k < 66; k++) rand_word(OpAppend);
        rand_word(OpQuery);
        rand_word(OpQuery);
      end
      if ($urandom_range(0, 5) != 0) rand_word(OpClear);
      nw = $urandom_range(0, 5);
      for (int k = 0; k < nw; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          c = rand_coord();
          wall(c, c ^ 16'h00ff, c, c ^ 16'h00ff);
        end else begin
          rand_word(OpAppend);
        end
      end
      nq = $urandom_range(1, 4);
      for (int k = 0; k < nq; k++) rand_word(OpQuery);
      if ($urandom_range(0, 7) == 0) rand_word(2'd3);
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS nearest_wall_line_distance");
    end else begin
      $display("FAIL nearest_wall_line_distance");
    end
    $finish;
  end

endmodule

FILE: nearest_wall_line_distance.f
design/nwld_pkg.sv
design/nwld_ram.sv
design/nearest_wall_line_distance.sv
dv/nwld_checker.sv
dv/nearest_wall_line_distance_tb.sv
